>>> hw/rtl/tpc_pkg.sv
// shared constants and types of the triangle plane clipper
package tpc_pkg;

   localparam int TPC_COORD_WIDTH     = 32;
   localparam int TPC_FRAC_BITS       = 16;
   localparam int TPC_CSR_INDEX_WIDTH = 3;

   typedef enum logic [TPC_CSR_INDEX_WIDTH-1:0] {
      CSR_POINT_X  = 3'd0,
      CSR_POINT_Y  = 3'd1,
      CSR_POINT_Z  = 3'd2,
      CSR_NORMAL_X = 3'd3,
      CSR_NORMAL_Y = 3'd4,
      CSR_NORMAL_Z = 3'd5
   } tpc_csr_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_ONE,
      MODE_TWO,
      MODE_ALL
   } tpc_mode_type;

endpackage

>>> hw/rtl/triangle_plane_clipper_core.sv
// top level of the triangle plane clipper: distances, edge fractions, new vertices
//
//   port group   dir   handshake           carries
//   req_*        in    req_valid/req_stall one triangle, three vertices
//   rsp_*        out   rsp_valid/rsp_stall one clipped triangle and is_last
//   csr_*        in    csr_we              plane point and normal registers
//
// the divider is most of the pipeline, one quotient bit per stage. a triangle
// enters every cycle while no output word waits; one that is split into two
// occupies the output register for two output words.
// when a word waits at the output the whole pipeline holds.
// reset clears valid bits and output phase; sets point (0,0,0.1), normal (0,0,1).
module triangle_plane_clipper_core #(
   parameter int COORD_WIDTH = tpc_pkg::TPC_COORD_WIDTH,
   parameter int FRAC_BITS   = tpc_pkg::TPC_FRAC_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_we,
   input  logic [tpc_pkg::TPC_CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COORD_WIDTH-1:0]                   csr_wdata,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [COORD_WIDTH-1:0]            req_a_x,
   input  logic signed [COORD_WIDTH-1:0]            req_a_y,
   input  logic signed [COORD_WIDTH-1:0]            req_a_z,
   input  logic signed [COORD_WIDTH-1:0]            req_b_x,
   input  logic signed [COORD_WIDTH-1:0]            req_b_y,
   input  logic signed [COORD_WIDTH-1:0]            req_b_z,
   input  logic signed [COORD_WIDTH-1:0]            req_c_x,
   input  logic signed [COORD_WIDTH-1:0]            req_c_y,
   input  logic signed [COORD_WIDTH-1:0]            req_c_z,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_a_x,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_a_y,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_a_z,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_b_x,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_b_y,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_b_z,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_c_x,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_c_y,
   output logic signed [COORD_WIDTH-1:0]            rsp_out_c_z,
   output logic                                     rsp_is_last
);
   import tpc_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int PW    = 2 * W;
   localparam int DW    = 2 * W + 3;
   localparam int UW    = DW - 1;
   localparam int TB    = W + 2;
   localparam int TL    = TB / 2;
   localparam int TH    = TB - TL;
   localparam int MW    = W + 1;
   localparam int NSIDE = TB + 4;
   localparam int OS    = TB + 3;

   localparam longint unsigned PZ_RESET = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;
   localparam longint unsigned NZ_RESET = 64'd1 << FRAC_BITS;

   typedef struct packed {
      tpc_mode_type                mode;
      logic [2:0][W-1:0]           first;
      logic [2:0][W-1:0]           second;
      logic [2:0][W-1:0]           third;
      logic [1:0][2:0][MW-1:0]     mag;
      logic [1:0][2:0]             neg;
   } side_type;

   // plane registers
   logic signed [W-1:0] pt_ff [3];
   logic signed [W-1:0] nm_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff[0] <= '0;
         pt_ff[1] <= '0;
         pt_ff[2] <= W'(PZ_RESET);
         nm_ff[0] <= '0;
         nm_ff[1] <= '0;
         nm_ff[2] <= W'(NZ_RESET);
      end else if (csr_we) begin
         case (tpc_csr_type'(csr_index))
            CSR_POINT_X:  pt_ff[0] <= csr_wdata;
            CSR_POINT_Y:  pt_ff[1] <= csr_wdata;
            CSR_POINT_Z:  pt_ff[2] <= csr_wdata;
            CSR_NORMAL_X: nm_ff[0] <= csr_wdata;
            CSR_NORMAL_Y: nm_ff[1] <= csr_wdata;
            CSR_NORMAL_Z: nm_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic advance;
   logic signed [W-1:0] vin [3][3];

   assign vin[0][0] = req_a_x;
   assign vin[0][1] = req_a_y;
   assign vin[0][2] = req_a_z;
   assign vin[1][0] = req_b_x;
   assign vin[1][1] = req_b_y;
   assign vin[1][2] = req_b_z;
   assign vin[2][0] = req_c_x;
   assign vin[2][1] = req_c_y;
   assign vin[2][2] = req_c_z;

   // stage 1: products
   logic                 v1_valid_ff;
   logic signed [PW-1:0] prod1_ff  [3][3];
   logic signed [PW-1:0] pprod1_ff [3];
   logic        [W-1:0]  v1_ff     [3][3];

   // stage 2: dot products
   logic                 v2_valid_ff;
   logic signed [DW-1:0] sum2_ff [3];
   logic signed [DW-1:0] pd2_ff;
   logic        [W-1:0]  v2_ff   [3][3];

   // stage 3: signed distances
   logic                 v3_valid_ff;
   logic signed [DW-1:0] d3_ff [3];
   logic        [W-1:0]  v3_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_valid_ff <= 1'b0;
         v2_valid_ff <= 1'b0;
         v3_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_valid_ff <= req_valid;
         v2_valid_ff <= v1_valid_ff;
         v3_valid_ff <= v2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int ax = 0; ax < 3; ax++) begin
            pprod1_ff[ax] <= nm_ff[ax] * pt_ff[ax];
            for (int k = 0; k < 3; k++) begin
               prod1_ff[k][ax] <= nm_ff[ax] * vin[k][ax];
               v1_ff[k][ax]    <= vin[k][ax];
            end
         end
         pd2_ff <= DW'(pprod1_ff[0]) + DW'(pprod1_ff[1]) + DW'(pprod1_ff[2]);
         for (int k = 0; k < 3; k++) begin
            sum2_ff[k] <= DW'(prod1_ff[k][0]) + DW'(prod1_ff[k][1]) + DW'(prod1_ff[k][2]);
            d3_ff[k]   <= sum2_ff[k] - pd2_ff;
         end
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // stage 4: classify and set up both edges
   logic [2:0]    kept;
   logic [1:0]    i0, i1, o0, o1;
   logic [1:0]    s_idx [2];
   logic [1:0]    e_idx [2];
   logic [MW-1:0] delta [2][3];
   logic [UW-1:0] num_in [2];
   logic [UW-1:0] den_in [2];
   side_type      side_in;

   assign kept = {!d3_ff[2][DW-1], !d3_ff[1][DW-1], !d3_ff[0][DW-1]};
   assign i0 = kept[0] ? 2'd0 : (kept[1] ? 2'd1 : 2'd2);
   assign i1 = kept[0] ? (kept[1] ? 2'd1 : 2'd2) : 2'd2;
   assign o0 = !kept[0] ? 2'd0 : (!kept[1] ? 2'd1 : 2'd2);
   assign o1 = !kept[0] ? (!kept[1] ? 2'd1 : 2'd2) : 2'd2;

   always_comb begin
      side_in = '0;
      case ($countones(kept))
         0:       side_in.mode = MODE_NONE;
         1:       side_in.mode = MODE_ONE;
         2:       side_in.mode = MODE_TWO;
         default: side_in.mode = MODE_ALL;
      endcase
      // second edge: from the lone inside vertex, or from the second inside one
      s_idx[0] = i0;
      e_idx[0] = o0;
      s_idx[1] = (side_in.mode == MODE_ONE) ? i0 : i1;
      e_idx[1] = (side_in.mode == MODE_ONE) ? o1 : o0;
      for (int ax = 0; ax < 3; ax++) begin
         side_in.first[ax]  = v3_ff[i0][ax];
         side_in.second[ax] = v3_ff[i1][ax];
         side_in.third[ax]  = v3_ff[2][ax];
      end
      for (int j = 0; j < 2; j++) begin
         num_in[j] = d3_ff[s_idx[j]][UW-1:0];
         den_in[j] = UW'(d3_ff[s_idx[j]] - d3_ff[e_idx[j]]);
         for (int ax = 0; ax < 3; ax++) begin
            delta[j][ax] = {v3_ff[e_idx[j]][ax][W-1], v3_ff[e_idx[j]][ax]}
                         - {v3_ff[s_idx[j]][ax][W-1], v3_ff[s_idx[j]][ax]};
            side_in.neg[j][ax] = delta[j][ax][MW-1];
            side_in.mag[j][ax] = delta[j][ax][MW-1] ? (~delta[j][ax] + 1'b1) : delta[j][ax];
         end
      end
   end

   logic          valid_ff [NSIDE];
   side_type      side_ff  [NSIDE];
   logic [UW-1:0] num_ff   [2];
   logic [UW-1:0] den_ff   [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSIDE; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= v3_valid_ff;
         for (int i = 1; i < NSIDE; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < NSIDE; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   // edge fractions t = d(S) / (d(S) - d(E)), below one
   logic [TB-1:0] quot [2];

   for (genvar j = 0; j < 2; j++) begin : g_div
      tpc_divider #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_div (
         .clock  (clock),
         .enable (advance),
         .num    (num_ff[j]),
         .den    (den_ff[j]),
         .quot   (quot[j])
      );
   end

   // offsets |E-S| * t, split into two partial products, then new vertices
   logic [MW+TL-1:0] pl_ff  [2][3];
   logic [MW+TH-1:0] ph_ff  [2][3];
   logic [W-1:0]     off_ff [2][3];
   logic [W-1:0]     x_ff   [2][3];
   logic [MW+TB-1:0] full   [2][3];
   logic [W-1:0]     sx     [2][3];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         for (int ax = 0; ax < 3; ax++) begin
            full[j][ax] = ((MW+TB)'(ph_ff[j][ax]) << TL) + (MW+TB)'(pl_ff[j][ax]);
            sx[j][ax]   = (j == 0 || side_ff[OS-1].mode == MODE_ONE)
                        ? side_ff[OS-1].first[ax] : side_ff[OS-1].second[ax];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 2; j++) begin
            for (int ax = 0; ax < 3; ax++) begin
               pl_ff[j][ax]  <= side_ff[TB].mag[j][ax] * quot[j][TL-1:0];
               ph_ff[j][ax]  <= side_ff[TB].mag[j][ax] * quot[j][TB-1:TL];
               off_ff[j][ax] <= full[j][ax][TB+W-1:TB];
               x_ff[j][ax]   <= side_ff[OS-1].neg[j][ax] ? sx[j][ax] - off_ff[j][ax]
                                                         : sx[j][ax] + off_ff[j][ax];
            end
         end
      end
   end

   // output word, split triangles take two output words
   logic         phase_ff;
   logic         has_rsp;
   logic         last;
   tpc_mode_type out_mode;
   logic [W-1:0] tri_p [3];
   logic [W-1:0] tri_q [3];
   logic [W-1:0] tri_r [3];

   assign out_mode = side_ff[OS].mode;
   assign has_rsp  = valid_ff[OS] && (out_mode != MODE_NONE);
   assign last     = (out_mode != MODE_TWO) || phase_ff;
   assign advance  = !has_rsp || (!rsp_stall && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else if (advance) begin
         phase_ff <= 1'b0;
      end else if (has_rsp && !rsp_stall) begin
         phase_ff <= 1'b1;
      end
   end

   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         case (out_mode)
            MODE_ONE: begin
               tri_p[ax] = side_ff[OS].first[ax];
               tri_q[ax] = x_ff[0][ax];
               tri_r[ax] = x_ff[1][ax];
            end
            MODE_TWO: begin
               tri_p[ax] = phase_ff ? side_ff[OS].second[ax] : side_ff[OS].first[ax];
               tri_q[ax] = phase_ff ? x_ff[0][ax] : side_ff[OS].second[ax];
               tri_r[ax] = phase_ff ? x_ff[1][ax] : x_ff[0][ax];
            end
            default: begin
               tri_p[ax] = side_ff[OS].first[ax];
               tri_q[ax] = side_ff[OS].second[ax];
               tri_r[ax] = side_ff[OS].third[ax];
            end
         endcase
      end
   end

   assign req_stall   = !advance;
   assign rsp_valid   = has_rsp;
   assign rsp_is_last = last;
   assign rsp_out_a_x = tri_p[0];
   assign rsp_out_a_y = tri_p[1];
   assign rsp_out_a_z = tri_p[2];
   assign rsp_out_b_x = tri_q[0];
   assign rsp_out_b_y = tri_q[1];
   assign rsp_out_b_z = tri_q[2];
   assign rsp_out_c_x = tri_r[0];
   assign rsp_out_c_y = tri_r[1];
   assign rsp_out_c_z = tri_r[2];

   // first half of a split triangle is always followed by its second half
   a_split_pair : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_is_last |=> rsp_valid && rsp_is_last)
      else $error("split triangle lost its second word");

   // input only held back by a pending output word
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && (rsp_stall || !rsp_is_last))
      else $error("input stalled with no output pending");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word present after reset");

endmodule

>>> hw/rtl/tpc_divider.sv
// pipelined restoring divider, one quotient bit per stage, for the edge fraction
module tpc_divider #(
   parameter int COORD_WIDTH = tpc_pkg::TPC_COORD_WIDTH
) (
   input  logic                      clock,
   input  logic                      enable,
   input  logic [2*COORD_WIDTH+1:0]  num,
   input  logic [2*COORD_WIDTH+1:0]  den,
   output logic [COORD_WIDTH+1:0]    quot
);
   import tpc_pkg::*;

   localparam int DW = 2 * COORD_WIDTH + 3;
   localparam int UW = DW - 1;
   localparam int TB = COORD_WIDTH + 2;

   logic [UW-1:0] rem_ff  [TB];
   logic [UW-1:0] den_ff  [TB];
   logic [TB-1:0] quot_ff [TB];

   for (genvar k = 0; k < TB; k++) begin : g_step
      logic [UW-1:0] rem_prev;
      logic [UW-1:0] den_prev;
      logic [TB-1:0] quot_prev;
      logic [DW-1:0] dbl;
      logic          take;

      if (k == 0) begin : g_first
         assign rem_prev  = num;
         assign den_prev  = den;
         assign quot_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign quot_prev = quot_ff[k-1];
      end

      assign dbl  = {rem_prev, 1'b0};
      assign take = dbl >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= take ? UW'(dbl - {1'b0, den_prev}) : dbl[UW-1:0];
            den_ff[k]  <= den_prev;
            quot_ff[k] <= {quot_prev[TB-2:0], take};
         end
      end
   end

   assign quot = quot_ff[TB-1];

endmodule
